// ===== rtl/lpsc_pkg.sv =====
// Shared constants, types and codes for the page slot cache.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package lpsc_pkg;

  // Number of page slots and the widths that follow from it.
  localparam int PAGE_SLOTS = 8;
  localparam int SLOT_W     = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
  localparam int CNT_W      = $clog2(PAGE_SLOTS + 1);

  // Fixed field widths.
  localparam int ADDR_W = 40;
  localparam int OFS_W  = 16;
  localparam int LEN_W  = 17;
  localparam int LG_W   = 5;

  // Legal page size range, as log2 of bytes.
  localparam logic [LG_W-1:0] LG_MIN   = 5'd6;
  localparam logic [LG_W-1:0] LG_MAX   = 5'd16;
  localparam logic [LG_W-1:0] LG_RESET = 5'd12;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_HIT   = 2'd0,
    ST_MISS  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Configuration register indexes.
  typedef enum logic {
    CFG_FILE_SIZE = 1'b0,
    CFG_PAGE_LOG2 = 1'b1
  } cfg_idx_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_UPDATE
  } fsm_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the input beat
    logic lookup;  // register the tag compare results
    logic commit;  // write the result and update slot state
  } cmd_t;

endpackage

// ===== rtl/lpsc_ctrl.sv =====
// Controller for the page slot cache: sequences lookup and update per beat.
// Depends on lpsc_pkg for the state enum and the command struct.
`timescale 1ns / 1ps

module lpsc_ctrl
  import lpsc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  fsm_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       commit;
  logic       load;

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands. A new beat is taken in the same cycle that
  // the previous one commits.
  always_comb begin
    commit        = (state_r == S_UPDATE) && (!out_valid_r || !out_stall);
    in_stall      = !((state_r == S_IDLE) || commit);
    load          = in_valid && !in_stall;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;

    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (load) state_nxt = S_LOOKUP;
      end
      S_LOOKUP: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        if (commit) state_nxt = load ? S_LOOKUP : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    cmd.load   = load;
    cmd.lookup = (state_r == S_LOOKUP);
    cmd.commit = commit;
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/lpsc_dp.sv =====
// Datapath for the page slot cache: config registers, slot tags, recency
// ranks, tag compare, victim choice and the result register. Uses lpsc_pkg.
`timescale 1ns / 1ps

module lpsc_dp
  import lpsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [ADDR_W-1:0] cfg_data,
  input  logic              in_kind,
  input  logic [ADDR_W-1:0] in_byte_index,
  output logic [1:0]        out_status,
  output logic [2:0]        out_slot,
  output logic [OFS_W-1:0]  out_page_offset,
  output logic              out_writeback_needed,
  output logic [ADDR_W-1:0] out_writeback_base,
  output logic [ADDR_W-1:0] out_fill_base,
  output logic [LEN_W-1:0]  out_fill_length
);

  // Configuration registers.
  logic [ADDR_W-1:0] file_size_r;
  logic [LG_W-1:0]   page_lg_r;

  // Captured input beat.
  logic              kind_r;
  logic [ADDR_W-1:0] idx_r;

  // Lookup stage registers.
  logic [PAGE_SLOTS-1:0] match_r, match_nxt;
  logic                  oor_r, oor_nxt;
  logic [ADDR_W-1:0]     fbase_r, fbase_nxt;
  logic [ADDR_W-1:0]     remain_r, remain_nxt;

  // Slot state. The rank of a slot is its place in the recency list,
  // zero being the most recent.
  logic [ADDR_W-1:0]     base_r  [PAGE_SLOTS];
  logic [PAGE_SLOTS-1:0] valid_r;
  logic [PAGE_SLOTS-1:0] dirty_r;
  logic [SLOT_W-1:0]     rank_r  [PAGE_SLOTS];
  logic [CNT_W-1:0]      used_r;

  // Result registers.
  status_t           status_r;
  logic [2:0]        slot_out_r;
  logic [OFS_W-1:0]  offset_r;
  logic              wb_need_r;
  logic [ADDR_W-1:0] wb_base_r;
  logic [ADDR_W-1:0] fill_base_r;
  logic [LEN_W-1:0]  fill_len_r;

  // Derived page geometry.
  logic [LG_W-1:0]   lg_eff;
  logic [LEN_W-1:0]  psize;
  logic [ADDR_W-1:0] page_mask;

  // Update stage signals.
  logic [ADDR_W:0]     diff [PAGE_SLOTS];
  logic                hit;
  logic [SLOT_W-1:0]   hit_slot;
  logic [SLOT_W-1:0]   lru_slot;
  logic [SLOT_W-1:0]   victim;
  logic [SLOT_W-1:0]   sel;
  logic [SLOT_W+2:0]   sel_ext;
  logic                full;
  logic                wb_need;
  logic [ADDR_W-1:0]   base_sel;
  logic [OFS_W-1:0]    offset;
  logic [LEN_W-1:0]    flen;
  logic [SLOT_W-1:0]   sel_rank;

  // Clamp the page size to its legal range and build the offset mask.
  always_comb begin
    if (page_lg_r < LG_MIN) begin
      lg_eff = LG_MIN;
    end else if (page_lg_r > LG_MAX) begin
      lg_eff = LG_MAX;
    end else begin
      lg_eff = page_lg_r;
    end
    psize     = LEN_W'(1) << lg_eff;
    page_mask = {{(ADDR_W - LEN_W){1'b0}}, psize - LEN_W'(1)};
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_size_r <= '0;
      page_lg_r   <= LG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FILE_SIZE: file_size_r <= cfg_data;
        CFG_PAGE_LOG2: page_lg_r   <= cfg_data[LG_W-1:0];
        default:       file_size_r <= file_size_r;
      endcase
    end
  end

  // Input capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      idx_r  <= in_byte_index;
    end
  end

  // Tag compare: a slot hits when base <= index < base + page size.
  always_comb begin
    for (int i = 0; i < PAGE_SLOTS; i++) begin
      diff[i]      = {1'b0, idx_r} - {1'b0, base_r[i]};
      match_nxt[i] = valid_r[i] && !diff[i][ADDR_W] &&
                     ((diff[i][ADDR_W-1:0] & ~page_mask) == '0);
    end
    oor_nxt    = (idx_r >= file_size_r);
    fbase_nxt  = idx_r & ~page_mask;
    remain_nxt = file_size_r - fbase_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      match_r  <= match_nxt;
      oor_r    <= oor_nxt;
      fbase_r  <= fbase_nxt;
      remain_r <= remain_nxt;
    end
  end

  // Slot choice. Slots fill in index order, so while the table is not
  // full the next free slot is the one numbered by the fill count.
  always_comb begin
    hit      = |match_r;
    hit_slot = '0;
    for (int i = PAGE_SLOTS - 1; i >= 0; i--) begin
      if (match_r[i]) hit_slot = SLOT_W'(i);
    end
    lru_slot = '0;
    for (int i = 0; i < PAGE_SLOTS; i++) begin
      if (rank_r[i] == SLOT_W'(PAGE_SLOTS - 1)) lru_slot = lru_slot | SLOT_W'(i);
    end
    full     = (used_r == CNT_W'(PAGE_SLOTS));
    victim   = full ? lru_slot : used_r[SLOT_W-1:0];
    sel      = hit ? hit_slot : victim;
    sel_ext  = {3'b000, sel};
    sel_rank = rank_r[sel];
    wb_need  = !hit && valid_r[victim] && dirty_r[victim];
    base_sel = hit ? base_r[hit_slot] : fbase_r;
    offset   = idx_r[OFS_W-1:0] - base_sel[OFS_W-1:0];
    if (remain_r > ADDR_W'(psize)) begin
      flen = psize;
    end else begin
      flen = remain_r[LEN_W-1:0];
    end
  end

  // Slot control state: valid, dirty, ranks and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dirty_r <= '0;
      used_r  <= '0;
      for (int i = 0; i < PAGE_SLOTS; i++) begin
        rank_r[i] <= SLOT_W'(i);
      end
    end else if (cmd.commit && !oor_r) begin
      // A filled slot starts clean unless this beat writes it.
      if (!hit) begin
        valid_r[victim] <= 1'b1;
        dirty_r[victim] <= kind_r;
        if (!full) used_r <= used_r + CNT_W'(1);
      end else if (kind_r) begin
        dirty_r[sel] <= 1'b1;
      end
      // Move the chosen slot to the front of the recency list.
      for (int i = 0; i < PAGE_SLOTS; i++) begin
        if (SLOT_W'(i) == sel) begin
          rank_r[i] <= '0;
        end else if (rank_r[i] < sel_rank) begin
          rank_r[i] <= rank_r[i] + SLOT_W'(1);
        end
      end
    end
  end

  // Slot base tags.
  always_ff @(posedge clk) begin
    if (cmd.commit && !oor_r && !hit) begin
      base_r[victim] <= fbase_r;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (oor_r) begin
        status_r    <= ST_RANGE;
        slot_out_r  <= '0;
        offset_r    <= '0;
        wb_need_r   <= 1'b0;
        wb_base_r   <= '0;
        fill_base_r <= '0;
        fill_len_r  <= '0;
      end else begin
        status_r    <= hit ? ST_HIT : ST_MISS;
        slot_out_r  <= sel_ext[2:0];
        offset_r    <= offset;
        wb_need_r   <= wb_need;
        wb_base_r   <= wb_need ? base_r[victim] : '0;
        fill_base_r <= hit ? '0 : fbase_r;
        fill_len_r  <= hit ? '0 : flen;
      end
    end
  end

  assign out_status           = status_r;
  assign out_slot             = slot_out_r;
  assign out_page_offset      = offset_r;
  assign out_writeback_needed = wb_need_r;
  assign out_writeback_base   = wb_base_r;
  assign out_fill_base        = fill_base_r;
  assign out_fill_length      = fill_len_r;

endmodule

// ===== rtl/lru_page_slot_cache.sv =====
// Top level of the fully associative page slot cache with LRU replacement.
// Instantiates lpsc_ctrl and lpsc_dp; uses lpsc_pkg.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_kind, in_byte_index
//   out      output     out_valid/out_stall  status, slot, page_offset, writeback_*,
//                                            fill_base, fill_length
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// Each beat runs through a lookup step, which compares the index against every
// slot tag in parallel, and an update step, which picks the slot, updates the
// recency ranks and loads the result register.
// Reset is synchronous and active low; it clears slot state at once.
// A stalled result holds the update step; input is taken again on commit.
`timescale 1ns / 1ps

module lru_page_slot_cache
  import lpsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [ADDR_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  input  logic [ADDR_W-1:0] in_byte_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [2:0]        out_slot,
  output logic [OFS_W-1:0]  out_page_offset,
  output logic              out_writeback_needed,
  output logic [ADDR_W-1:0] out_writeback_base,
  output logic [ADDR_W-1:0] out_fill_base,
  output logic [LEN_W-1:0]  out_fill_length
);

  cmd_t cmd;

  // Sequencer for the lookup and update steps.
  lpsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Tags, recency state and result register.
  lpsc_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_kind              (in_kind),
    .in_byte_index        (in_byte_index),
    .out_status           (out_status),
    .out_slot             (out_slot),
    .out_page_offset      (out_page_offset),
    .out_writeback_needed (out_writeback_needed),
    .out_writeback_base   (out_writeback_base),
    .out_fill_base        (out_fill_base),
    .out_fill_length      (out_fill_length)
  );

endmodule
